>>> src/led_chain_serial_shifter_assert.svh
// ---------------------------------------------------------------------------
// LED chain serial shifter assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef LED_CHAIN_SERIAL_SHIFTER_ASSERT_SVH
`define LED_CHAIN_SERIAL_SHIFTER_ASSERT_SVH
`ifndef SYNTHESIS
`define LCS_ASSERT_COMB(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define LCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LCS_ASSERT_COMB(lbl, cond, msg)
`define LCS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> src/lcs_pkg.sv
// ---------------------------------------------------------------------------
// LED chain serial shifter package
// Chain size, request, status and phase codes, register map and beat types.
// ---------------------------------------------------------------------------
package lcs_pkg;

  localparam int LED_COUNT = 8;
  localparam int LED_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int TRK_N     = 4;
  localparam int TRK_W     = 2;
  localparam int COLOR_W   = 24;

  localparam logic [LED_W-1:0] TRK_BASE = LED_W'(LED_COUNT - TRK_N);
  localparam logic [LED_W-1:0] LED_LAST = LED_W'(LED_COUNT - 1);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_START = 2'd1;
  localparam logic [1:0] PH_HIGH  = 2'd2;
  localparam logic [1:0] PH_LOW   = 2'd3;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_SET   = 2'd1;
  localparam logic [1:0] REQ_ACT   = 2'd2;
  localparam logic [1:0] REQ_DEACT = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NO_LED = 2'd1;
  localparam logic [1:0] ST_BUSY   = 2'd2;

  localparam logic [1:0] TAG_ZERO = 2'd0;
  localparam logic [1:0] TAG_SNAP = 2'd1;
  localparam logic [1:0] TAG_RAM  = 2'd2;

  localparam logic [1:0] DOP_HOLD = 2'd0;
  localparam logic [1:0] DOP_ZERO = 2'd1;
  localparam logic [1:0] DOP_BIT  = 2'd2;

  localparam logic [2:0] CFG_START_DELAY = 3'd0;
  localparam logic [2:0] CFG_REVERSE     = 3'd1;
  localparam logic [2:0] CFG_TRACK_A     = 3'd2;
  localparam logic [2:0] CFG_TRACK_B     = 3'd3;
  localparam logic [2:0] CFG_TRACK_C     = 3'd4;
  localparam logic [2:0] CFG_TRACK_D     = 3'd5;

  localparam logic [7:0]         START_DELAY_RST = 8'd150;
  localparam logic [COLOR_W-1:0] TRACK_A_RST     = 24'h00FF00;
  localparam logic [COLOR_W-1:0] TRACK_B_RST     = 24'h00FF00;
  localparam logic [COLOR_W-1:0] TRACK_C_RST     = 24'h0000FF;
  localparam logic [COLOR_W-1:0] TRACK_D_RST     = 24'h0000FF;

  typedef struct packed {
    logic [7:0]                     start_delay;
    logic                           reverse;
    logic [TRK_N-1:0][COLOR_W-1:0]  track;
  } cfg_t;

  typedef struct packed {
    logic       clk_lvl;
    logic [1:0] status;
    logic       busy;
    logic [1:0] dop;
    logic       src_ram;
    logic       pre_bit;
    logic [1:0] sel_byte;
    logic [2:0] sel_bit;
  } beat_t;

endpackage

>>> src/led_chain_serial_shifter.sv
// Path: a taken request beat is registered in s1, then in the output stage.
// Throughput: one request per cycle while out_ready keeps the output stage moving,
// set by the sequencer update and the registered colour store read that feeds it.
// Reset: row tags clear so every LED shifts out zero, a frame starts with the
// reset start delay, registers take their reset values; no clearing pass is needed.
// ---------------------------------------------------------------------------
// LED chain serial shifter
// Colour store, sequencer, output stage and register port for a two-wire chain.
// ---------------------------------------------------------------------------
`include "led_chain_serial_shifter_assert.svh"

module led_chain_serial_shifter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [7:0]  led_index,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        serial_clock,
  output logic        serial_data,
  output logic [1:0]  status,
  output logic        busy_res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import lcs_pkg::*;

  cfg_t                cfg;
  beat_t               beat, s1;
  logic                s1_valid, s1_adv, accept;
  logic                data_level, data_next;
  logic                ram_we, ram_re;
  logic [TRK_W-1:0]    ram_waddr, ram_raddr;
  logic [COLOR_W-1:0]  ram_wdata, ram_rdata;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_delay <= START_DELAY_RST;
      cfg.reverse     <= 1'b0;
      cfg.track[0]    <= TRACK_A_RST;
      cfg.track[1]    <= TRACK_B_RST;
      cfg.track[2]    <= TRACK_C_RST;
      cfg.track[3]    <= TRACK_D_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_START_DELAY: cfg.start_delay <= cfg_data[7:0];
        CFG_REVERSE:     cfg.reverse     <= cfg_data[0];
        CFG_TRACK_A:     cfg.track[0]    <= cfg_data;
        CFG_TRACK_B:     cfg.track[1]    <= cfg_data;
        CFG_TRACK_C:     cfg.track[2]    <= cfg_data;
        CFG_TRACK_D:     cfg.track[3]    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !rst && (!s1_valid || s1_adv);
  assign accept   = in_valid && in_ready;

  lcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req_type  (req_type),
    .led_index (led_index),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .cfg       (cfg),
    .beat      (beat),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr)
  );

  lcs_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (TRK_N)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= beat;
    end
  end

  always_comb begin
    case (s1.dop)
      DOP_ZERO: data_next = 1'b0;
      DOP_BIT:  data_next = s1.src_ram ? ram_rdata[{s1.sel_byte, s1.sel_bit}] : s1.pre_bit;
      default:  data_next = data_level;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      data_level <= 1'b0;
    end else if (s1_adv) begin
      out_valid  <= 1'b1;
      data_level <= data_next;
    end else if (out_ready) begin
      out_valid  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      serial_clock <= s1.clk_lvl;
      status       <= s1.status;
      busy_res     <= s1.busy;
    end
  end

  assign serial_data = data_level;

  `LCS_ASSERT_COMB(a_no_overrun, !(accept && s1_valid && out_valid && !out_ready), "stage overrun")
  `LCS_ASSERT_NEXT(a_out_loaded, s1_adv, out_valid, "output stage lost a beat")
  `LCS_ASSERT_COMB(a_idle_clock_high, !(out_valid && !busy_res) || serial_clock, "idle clock low")

endmodule

>>> src/lcs_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one read port, read data registered.
// ---------------------------------------------------------------------------
module lcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/lcs_ctrl.sv
// ---------------------------------------------------------------------------
// LED chain serial shifter sequencer
// Frame phase, bit position, row tags and store write and read requests.
// ---------------------------------------------------------------------------
module lcs_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [1:0]                  req_type,
  input  logic [7:0]                  led_index,
  input  logic [7:0]                  red,
  input  logic [7:0]                  green,
  input  logic [7:0]                  blue,
  input  lcs_pkg::cfg_t               cfg,
  output lcs_pkg::beat_t              beat,
  output logic                        ram_we,
  output logic [lcs_pkg::TRK_W-1:0]   ram_waddr,
  output logic [lcs_pkg::COLOR_W-1:0] ram_wdata,
  output logic                        ram_re,
  output logic [lcs_pkg::TRK_W-1:0]   ram_raddr
);
  import lcs_pkg::*;

  logic [1:0]       phase, phase_next;
  logic [LED_W-1:0] led_pos, led_next;
  logic [1:0]       byte_pos, byte_next;
  logic [3:0]       bit_pos, bit_next;
  logic [7:0]       delay_count, delay_next;
  logic             clk_lvl, clk_next;
  logic [TRK_N-1:0][1:0]         tag, tag_next;
  logic [TRK_N-1:0][COLOR_W-1:0] snap, snap_next;

  logic             adv_bump, adv_wrap, adv_done;
  logic [3:0]       adv_bit, emit_bit;
  logic [1:0]       adv_byte, sel_byte;
  logic [LED_W-1:0] adv_led;
  logic             tracked;
  logic [TRK_W-1:0] trk;
  logic             emit, set_ok;
  logic [1:0]       status, dop;

  always_comb begin
    adv_bump = (bit_pos == 4'd0);
    adv_wrap = adv_bump && (byte_pos == 2'd2);
    adv_done = adv_wrap && (led_pos == LED_LAST);
    adv_bit  = adv_bump ? 4'd8 : bit_pos;
    adv_byte = adv_wrap ? 2'd0 : (adv_bump ? 2'(byte_pos + 2'd1) : byte_pos);
    adv_led  = adv_done ? '0 : (adv_wrap ? LED_W'(led_pos + 1'b1) : led_pos);
    emit_bit = adv_bit - 4'd1;
    sel_byte = cfg.reverse ? 2'(2'd2 - adv_byte) : adv_byte;
    tracked  = (adv_led >= TRK_BASE);
    trk      = TRK_W'(adv_led - TRK_BASE);
  end

  always_comb begin
    phase_next = phase;
    led_next   = led_pos;
    byte_next  = byte_pos;
    bit_next   = bit_pos;
    delay_next = delay_count;
    clk_next   = clk_lvl;
    tag_next   = tag;
    snap_next  = snap;
    status     = ST_OK;
    dop        = DOP_HOLD;
    emit       = 1'b0;
    set_ok     = 1'b0;
    unique case (req_type)
      REQ_TICK: begin
        unique case (phase)
          PH_START: begin
            clk_next = 1'b0;
            if (delay_count == 8'd0) begin
              emit       = 1'b1;
              phase_next = PH_HIGH;
            end else begin
              delay_next = delay_count - 8'd1;
            end
          end
          PH_HIGH: begin
            clk_next   = 1'b1;
            led_next   = adv_led;
            byte_next  = adv_byte;
            bit_next   = adv_bit;
            phase_next = adv_done ? PH_IDLE : PH_LOW;
          end
          PH_LOW: begin
            clk_next   = 1'b0;
            emit       = 1'b1;
            phase_next = PH_HIGH;
          end
          PH_IDLE: begin
            clk_next = 1'b1;
            dop      = DOP_ZERO;
          end
        endcase
      end
      REQ_SET: begin
        if (led_index > 8'd3) begin
          status = ST_NO_LED;
        end else if (phase != PH_IDLE) begin
          status = ST_BUSY;
        end else begin
          set_ok                     = 1'b1;
          tag_next[led_index[1:0]]   = TAG_RAM;
          phase_next                 = PH_START;
          delay_next                 = cfg.start_delay;
        end
      end
      REQ_ACT: begin
        snap_next  = cfg.track;
        tag_next   = {TRK_N{TAG_SNAP}};
        phase_next = PH_START;
        delay_next = cfg.start_delay;
      end
      REQ_DEACT: begin
        tag_next   = {TRK_N{TAG_ZERO}};
        phase_next = PH_START;
        delay_next = cfg.start_delay;
      end
    endcase
    if (emit) begin
      led_next  = adv_led;
      byte_next = adv_byte;
      bit_next  = emit_bit;
      dop       = DOP_BIT;
    end
  end

  always_comb begin
    beat.clk_lvl  = clk_next;
    beat.status   = status;
    beat.busy     = (phase_next != PH_IDLE);
    beat.dop      = dop;
    beat.src_ram  = tracked && (tag[trk] == TAG_RAM);
    beat.pre_bit  = tracked && (tag[trk] == TAG_SNAP) && snap[trk][{sel_byte, emit_bit[2:0]}];
    beat.sel_byte = sel_byte;
    beat.sel_bit  = emit_bit[2:0];
  end

  assign ram_we    = accept && set_ok;
  assign ram_waddr = led_index[TRK_W-1:0];
  assign ram_wdata = {red, green, blue};
  assign ram_re    = accept && emit;
  assign ram_raddr = trk;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      led_pos     <= '0;
      byte_pos    <= 2'd0;
      bit_pos     <= 4'd8;
      delay_count <= START_DELAY_RST;
      clk_lvl     <= 1'b1;
      tag         <= {TRK_N{TAG_ZERO}};
    end else if (accept) begin
      phase       <= phase_next;
      led_pos     <= led_next;
      byte_pos    <= byte_next;
      bit_pos     <= bit_next;
      delay_count <= delay_next;
      clk_lvl     <= clk_next;
      tag         <= tag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      snap <= snap_next;
    end
  end

endmodule

>>> tb/tb_led_chain_serial_shifter.sv
// ---------------------------------------------------------------------------
// LED chain serial shifter testbench
// Drives tick, set-colour, activate and deactivate requests through the
// request channel and compares every result beat with a cycle-free model of
// the chain sequencer or a directed row's beat. A short directed table opens the
// run; random requests follow, shaped by the model state to reach idle frames,
// byte boundaries and the wrap after the last LED, under several register settings.
// ---------------------------------------------------------------------------
module tb_led_chain_serial_shifter;
  timeunit 1ns;
  timeprecision 1ps;
  import lcs_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int LONG_HOLD    = 150;
  localparam int RANDOM_ITEMS = 1050;
  localparam int PHASES       = 6;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_AFTER   = 300;

  typedef struct packed {
    logic       serial_clock;
    logic       serial_data;
    logic [1:0] status;
    logic       busy_res;
  } chain_out_t;

  typedef struct {
    logic [1:0] req;
    logic [7:0] idx;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    int         reps;
    bit         typed;
    chain_out_t res;
  } dir_row_t;

  localparam chain_out_t START_LOW  = '{1'b0, 1'b0, ST_OK, 1'b1};
  localparam chain_out_t NO_LED_LOW = '{1'b0, 1'b0, ST_NO_LED, 1'b1};
  localparam chain_out_t BUSY_LOW   = '{1'b0, 1'b0, ST_BUSY, 1'b1};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  req_type = REQ_TICK;
  logic [7:0]  led_index = 8'h00;
  logic [7:0]  red = 8'h00;
  logic [7:0]  green = 8'h00;
  logic [7:0]  blue = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        serial_clock;
  logic        serial_data;
  logic [1:0]  status;
  logic        busy_res;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = CFG_START_DELAY;
  logic [23:0] cfg_data = 24'h000000;

  logic [7:0]         cfg_start_delay;
  logic               cfg_reverse;
  logic [COLOR_W-1:0] cfg_track [TRK_N];

  logic [7:0] chain_store [LED_COUNT*3];
  logic [1:0] chain_phase;
  logic [7:0] frame_led;
  logic [1:0] frame_byte;
  logic [3:0] frame_bit;
  logic [7:0] delay_left;
  logic       line_clk;
  logic       line_data;

  chain_out_t line_expect_q [$];
  int         mismatch_count = 0;
  int         results_seen = 0;
  int         stall_cycles = 0;
  bit         no_idle = 1'b0;
  bit         long_hold_done = 1'b0;

  dir_row_t directed_rows [9] = '{
    '{REQ_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1,  1'b1, START_LOW},
    '{REQ_SET,   8'hFF, 8'hFF, 8'hFF, 8'hFF, 1,  1'b1, NO_LED_LOW},
    '{REQ_SET,   8'h04, 8'h00, 8'h00, 8'h00, 1,  1'b1, NO_LED_LOW},
    '{REQ_SET,   8'h03, 8'hFF, 8'hFF, 8'hFF, 1,  1'b1, BUSY_LOW},
    '{REQ_SET,   8'h00, 8'h00, 8'h00, 8'h00, 1,  1'b1, BUSY_LOW},
    '{REQ_DEACT, 8'h00, 8'h00, 8'h00, 8'h00, 1,  1'b1, START_LOW},
    '{REQ_TICK,  8'hA5, 8'h5A, 8'hC3, 8'h3C, 15, 1'b0, START_LOW},
    '{REQ_ACT,   8'h5A, 8'hA5, 8'h3C, 8'hC3, 1,  1'b0, START_LOW},
    '{REQ_TICK,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 3,  1'b0, START_LOW}
  };

  led_chain_serial_shifter i_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void frame_restart();
    chain_phase = PH_START;
    delay_left  = cfg_start_delay;
  endfunction

  function automatic bit frame_advance();
    if (frame_bit == 4'd0) begin
      frame_byte++;
      frame_bit = 4'd8;
    end
    if (frame_byte == 2'd3) begin
      frame_byte = 2'd0;
      frame_led++;
    end
    if (frame_led >= LED_COUNT) begin
      frame_led = 8'd0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void shift_next_bit();
    int k;
    int idx;
    if (frame_bit == 4'd0)
      void'(frame_advance());
    frame_bit--;
    k   = cfg_reverse ? 2 - int'(frame_byte) : int'(frame_byte);
    idx = int'(frame_led) * 3 + k;
    if (idx >= LED_COUNT * 3)
      idx = 0;
    line_data = chain_store[idx][frame_bit[2:0]];
  endfunction

  function automatic void tracked_fill(bit load);
    int base;
    logic [COLOR_W-1:0] c;
    for (int i = 0; i < TRK_N; i++) begin
      base = (LED_COUNT - TRK_N + i) * 3;
      c    = load ? cfg_track[i] : '0;
      chain_store[base]     = c[7:0];
      chain_store[base + 1] = c[15:8];
      chain_store[base + 2] = c[23:16];
    end
    frame_restart();
  endfunction

  function automatic void chain_reset();
    cfg_start_delay = START_DELAY_RST;
    cfg_reverse     = 1'b0;
    cfg_track[0]    = TRACK_A_RST;
    cfg_track[1]    = TRACK_B_RST;
    cfg_track[2]    = TRACK_C_RST;
    cfg_track[3]    = TRACK_D_RST;
    foreach (chain_store[i])
      chain_store[i] = 8'h00;
    frame_led  = 8'd0;
    frame_byte = 2'd0;
    frame_bit  = 4'd8;
    line_clk   = 1'b1;
    line_data  = 1'b0;
    frame_restart();
  endfunction

  function automatic chain_out_t shift_step(logic [1:0] req, logic [7:0] idx,
                                            logic [7:0] r, logic [7:0] g, logic [7:0] b);
    chain_out_t res;
    int base;
    res.status = ST_OK;
    case (req)
      REQ_TICK: begin
        case (chain_phase)
          PH_START: begin
            line_clk = 1'b0;
            if (delay_left == 8'd0) begin
              shift_next_bit();
              chain_phase = PH_HIGH;
            end else
              delay_left--;
          end
          PH_HIGH: begin
            line_clk    = 1'b1;
            chain_phase = frame_advance() ? PH_IDLE : PH_LOW;
          end
          PH_LOW: begin
            line_clk = 1'b0;
            shift_next_bit();
            chain_phase = PH_HIGH;
          end
          default: begin
            line_clk  = 1'b1;
            line_data = 1'b0;
          end
        endcase
      end
      REQ_SET: begin
        if (idx >= TRK_N)
          res.status = ST_NO_LED;
        else if (chain_phase != PH_IDLE)
          res.status = ST_BUSY;
        else begin
          base = (LED_COUNT - TRK_N + int'(idx)) * 3;
          chain_store[base]     = b;
          chain_store[base + 1] = g;
          chain_store[base + 2] = r;
          frame_restart();
        end
      end
      default: tracked_fill(req == REQ_ACT);
    endcase
    res.serial_clock = line_clk;
    res.serial_data  = line_data;
    res.busy_res     = (chain_phase != PH_IDLE);
    return res;
  endfunction

  function automatic int idle_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60)
      return 0;
    if (roll < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_req(input logic [1:0] req, input logic [7:0] idx,
                          input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                          input bit typed, input chain_out_t typed_res);
    chain_out_t predicted;
    int gap;
    in_valid  <= 1'b1;
    req_type  <= req;
    led_index <= idx;
    red       <= r;
    green     <= g;
    blue      <= b;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    predicted = shift_step(req, idx, r, g, b);
    line_expect_q.push_back(typed ? typed_res : predicted);
    gap = no_idle ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [23:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    case (idx) inside
      CFG_START_DELAY: cfg_start_delay = data[7:0];
      CFG_REVERSE:     cfg_reverse = data[0];
      CFG_TRACK_A, CFG_TRACK_B, CFG_TRACK_C, CFG_TRACK_D:
        cfg_track[2'(idx - CFG_TRACK_A)] = data;
      default: ;
    endcase
  endtask

  task automatic random_req();
    logic [1:0] req;
    logic [7:0] idx;
    int roll;
    bit byte_done;
    bit wrap_due;
    req       = REQ_TICK;
    idx       = 8'($urandom_range(0, 255));
    roll      = $urandom_range(0, 999);
    byte_done = (chain_phase == PH_HIGH) && (frame_bit == 4'd0);
    wrap_due  = byte_done && (frame_byte == 2'd2) && (frame_led == LED_COUNT - 1);
    if (chain_phase == PH_IDLE) begin
      if (roll < 300) begin
        req = REQ_SET;
        idx = 8'($urandom_range(0, TRK_N - 1));
      end else if (roll < 400)
        req = $urandom_range(0, 1) ? REQ_ACT : REQ_DEACT;
      else if (roll < 500) begin
        req = REQ_SET;
        idx = 8'($urandom_range(TRK_N, 255));
      end
    end else if ((wrap_due && roll < 250) || (byte_done && roll < 16) || roll < 4)
      req = $urandom_range(0, 1) ? REQ_ACT : REQ_DEACT;
    else if (roll < 14)
      req = REQ_SET;
    send_req(req, idx, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, START_LOW);
  endtask

  initial begin : stimulus
    logic [7:0]         ph_delay;
    logic               ph_rev;
    logic [COLOR_W-1:0] ph_track [TRK_N];
    chain_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    reg_write(CFG_START_DELAY, {16'($urandom), 8'd0});
    cfg_valid <= 1'b0;
    foreach (directed_rows[i])
      for (int n = 0; n < directed_rows[i].reps; n++)
        send_req(directed_rows[i].req, directed_rows[i].idx, directed_rows[i].r,
                 directed_rows[i].g, directed_rows[i].b, directed_rows[i].typed,
                 directed_rows[i].res);
    for (int p = 0; p < PHASES; p++) begin
      in_valid <= 1'b0;
      while (line_expect_q.size() != 0)
        @(posedge clk);
      foreach (ph_track[i])
        ph_track[i] = COLOR_W'($urandom);
      case (p)
        0: begin
          ph_delay = 8'd0;
          ph_rev   = 1'b0;
          ph_track[0] = 24'hFFFFFF;
          ph_track[1] = 24'h000000;
          ph_track[2] = 24'h800001;
          ph_track[3] = 24'h7FFFFE;
        end
        1: begin
          ph_delay = 8'd255;
          ph_rev   = 1'b1;
          ph_track[0] = 24'h000000;
          ph_track[1] = 24'hFFFFFF;
        end
        2: begin
          ph_delay = 8'd1;
          ph_rev   = 1'b1;
        end
        3: begin
          ph_delay = 8'($urandom_range(0, 7));
          ph_rev   = 1'b0;
        end
        4: begin
          ph_delay = 8'd0;
          ph_rev   = 1'b1;
        end
        default: begin
          ph_delay = 8'($urandom);
          ph_rev   = 1'($urandom);
        end
      endcase
      no_idle = (p == 2);
      reg_write(CFG_START_DELAY, {16'($urandom), ph_delay});
      reg_write(CFG_REVERSE, {23'($urandom), ph_rev});
      reg_write(CFG_TRACK_A, ph_track[0]);
      reg_write(CFG_TRACK_B, ph_track[1]);
      reg_write(CFG_TRACK_C, ph_track[2]);
      reg_write(CFG_TRACK_D, ph_track[3]);
      cfg_valid <= 1'b0;
      repeat (RANDOM_ITEMS / PHASES) random_req();
    end
    in_valid <= 1'b0;
    while (line_expect_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("led_chain_serial_shifter regression: pass");
    else
      $display("led_chain_serial_shifter regression: fail");
    $finish;
  end

  initial begin : result_sink
    int gap;
    while (rst)
      @(posedge clk);
    forever begin
      if (!long_hold_done && results_seen >= HOLD_AFTER && in_valid) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_done = 1'b1;
      end else begin
        gap = no_idle ? 0 : idle_gap();
        if (gap == 0) begin
          out_ready <= 1'b1;
          @(posedge clk);
        end else begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    chain_out_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (line_expect_q.size() == 0) begin
        $error("result beat with no request outstanding");
        mismatch_count++;
      end else begin
        want = line_expect_q.pop_front();
        if (serial_clock !== want.serial_clock) begin
          $error("serial_clock: expected %0b, got %0b", want.serial_clock, serial_clock);
          mismatch_count++;
        end
        if (serial_data !== want.serial_data) begin
          $error("serial_data: expected %0b, got %0b", want.serial_data, serial_data);
          mismatch_count++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          mismatch_count++;
        end
        if (busy_res !== want.busy_res) begin
          $error("busy_res: expected %0b, got %0b", want.busy_res, busy_res);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else if (stall_cycles == STALL_LIMIT) begin
      $display("led_chain_serial_shifter regression: fail");
      $finish;
    end else
      stall_cycles <= stall_cycles + 1;
  end

endmodule
